### src/pol_pkg.sv
// pol_pkg: shared types, codes and sizes for the positional ordered list.
// No dependencies; every other file in src refers to it by scoped names.
package pol_pkg;

  localparam int DEPTH_DEF = 16;   // default list capacity
  localparam int ELEM_W    = 32;
  localparam int POS_W     = 8;
  localparam int FUNC_W    = 3;
  localparam int STAT_W    = 2;
  localparam int LEN_W     = 5;

  // operation selector
  typedef enum logic [FUNC_W-1:0] {
    F_INS_HEAD = 3'd0,
    F_INS_TAIL = 3'd1,
    F_INS_AT   = 3'd2,
    F_DEL_HEAD = 3'd3,
    F_DEL_AT   = 3'd4,
    F_DEL_TAIL = 3'd5,
    F_DUMP     = 3'd6
  } func_t;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [ELEM_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [ELEM_W-1:0] element;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // take the input word
    logic execute;     // apply the held operation and load its result
    logic dump_start;  // clear the dump pointer
    logic dump_step;   // load one dumped element, advance the pointer
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_dump;
    logic empty;
    logic out_free;
    logic dump_last;
  } dp_stat_t;

endpackage

### src/pol_ctrl.sv
// pol_ctrl: sequencing state machine of the positional ordered list.
// Depends on pol_pkg for the state, command and status types.
module pol_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pol_pkg::dp_stat_t     stat,
  output pol_pkg::ctl_cmd_t     cmd
);

  pol_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pol_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pol_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pol_pkg::S_EXEC;
      end
      pol_pkg::S_EXEC: begin
        if (stat.out_free) begin
          if (stat.is_dump && !stat.empty) state_nxt = pol_pkg::S_DUMP;
          else                             state_nxt = pol_pkg::S_IDLE;
        end
      end
      pol_pkg::S_DUMP: begin
        if (stat.out_free && stat.dump_last) state_nxt = pol_pkg::S_IDLE;
      end
      default: state_nxt = pol_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      pol_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      pol_pkg::S_EXEC: begin
        if (stat.out_free) begin
          if (stat.is_dump && !stat.empty) cmd.dump_start = 1'b1;
          else                             cmd.execute    = 1'b1;
        end
      end
      pol_pkg::S_DUMP: begin
        cmd.dump_step = stat.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

### src/pol_datapath.sv
// pol_datapath: element cell chain, count, operation decode and result register.
// Depends on pol_pkg; driven by pol_ctrl through ctl_cmd_t.
module pol_datapath #(
  parameter int LIST_DEPTH = pol_pkg::DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pol_pkg::in_word_t     in_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output pol_pkg::out_word_t    out_data,
  input  pol_pkg::ctl_cmd_t     cmd,
  output pol_pkg::dp_stat_t     stat
);

  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int IXW = $clog2(LIST_DEPTH);
  localparam int PW  = (CW > pol_pkg::POS_W) ? CW + 1 : pol_pkg::POS_W + 1;

  // held input word
  logic [pol_pkg::FUNC_W-1:0]        func_r;
  logic signed [pol_pkg::ELEM_W-1:0] value_r;
  logic [pol_pkg::POS_W-1:0]         pos_r;

  logic [CW-1:0]  count_r, count_nxt;
  logic [IXW-1:0] dix_r;

  logic signed [pol_pkg::ELEM_W-1:0] store_r [LIST_DEPTH];
  logic signed [pol_pkg::ELEM_W-1:0] from_prev [LIST_DEPTH];
  logic signed [pol_pkg::ELEM_W-1:0] from_next [LIST_DEPTH];

  pol_pkg::out_word_t out_r;
  logic               out_valid_r;

  logic              full, empty, do_ins, do_del, dump_last;
  logic [PW-1:0]     cnt_x, pos_m1, pos0;
  logic [pol_pkg::STAT_W-1:0] op_status;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_data.func;
      value_r <= in_data.value;
      pos_r   <= in_data.position;
    end
  end

  // operation decode
  always_comb begin
    full      = (count_r == CW'(LIST_DEPTH));
    empty     = (count_r == '0);
    cnt_x     = PW'(count_r);
    pos_m1    = PW'(pos_r) - PW'(1);
    do_ins    = 1'b0;
    do_del    = 1'b0;
    pos0      = '0;
    op_status = pol_pkg::ST_OK;
    case (func_r)
      pol_pkg::F_INS_HEAD: begin
        if (full) op_status = pol_pkg::ST_FULL;
        else      do_ins    = 1'b1;
      end
      pol_pkg::F_INS_TAIL: begin
        pos0 = cnt_x;
        if (full) op_status = pol_pkg::ST_FULL;
        else      do_ins    = 1'b1;
      end
      pol_pkg::F_INS_AT: begin
        pos0 = pos_m1;
        if (full)                                op_status = pol_pkg::ST_FULL;
        else if (pos_r == '0 || pos_m1 > cnt_x) op_status = pol_pkg::ST_RANGE;
        else                                     do_ins    = 1'b1;
      end
      pol_pkg::F_DEL_HEAD: begin
        if (empty) op_status = pol_pkg::ST_EMPTY;
        else       do_del    = 1'b1;
      end
      pol_pkg::F_DEL_AT: begin
        pos0 = pos_m1;
        if (empty)                                op_status = pol_pkg::ST_EMPTY;
        else if (pos_r == '0 || pos_m1 >= cnt_x) op_status = pol_pkg::ST_RANGE;
        else                                      do_del    = 1'b1;
      end
      pol_pkg::F_DEL_TAIL: begin
        pos0 = cnt_x - PW'(1);
        if (empty) op_status = pol_pkg::ST_EMPTY;
        else       do_del    = 1'b1;
      end
      default: op_status = pol_pkg::ST_OK;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) count_nxt = count_r + CW'(1);
    if (do_del) count_nxt = count_r - CW'(1);
  end

  // neighbour taps of the cell chain
  always_comb begin
    from_prev[0]            = value_r;
    from_next[LIST_DEPTH-1] = store_r[LIST_DEPTH-1];
    for (int i = 1; i < LIST_DEPTH; i++) begin
      from_prev[i]   = store_r[i-1];
      from_next[i-1] = store_r[i];
    end
  end

  // each cell takes the new value, its upstream or downstream neighbour, or holds
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        if (do_ins && PW'(i) == pos0)      store_r[i] <= value_r;
        else if (do_ins && PW'(i) > pos0)  store_r[i] <= from_prev[i];
        else if (do_del && PW'(i) >= pos0) store_r[i] <= from_next[i];
      end
    end
  end

  assign dump_last = (CW'(dix_r) == count_r - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dix_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.execute) count_r <= count_nxt;
      if (cmd.dump_start)     dix_r <= '0;
      else if (cmd.dump_step) dix_r <= dix_r + IXW'(1);
      if (cmd.execute || cmd.dump_step) out_valid_r <= 1'b1;
      else if (!out_stall)              out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_r.status  <= op_status;
      out_r.element <= '0;
      out_r.length  <= pol_pkg::LEN_W'(count_nxt);
      out_r.last    <= 1'b1;
    end else if (cmd.dump_step) begin
      out_r.status  <= pol_pkg::ST_OK;
      out_r.element <= store_r[dix_r];
      out_r.length  <= pol_pkg::LEN_W'(count_r);
      out_r.last    <= dump_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    stat.is_dump   = (func_r == pol_pkg::F_DUMP);
    stat.empty     = empty;
    stat.out_free  = !out_valid_r || !out_stall;
    stat.dump_last = dump_last;
  end

endmodule

### src/positional_ordered_list.sv
// positional_ordered_list: top level of the bounded positional list.
// Depends on pol_pkg, pol_ctrl and pol_datapath.
//
//   channel   direction  ports                          word type
//   in_       input      in_valid, in_stall, in_data    pol_pkg::in_word_t
//   out_      output     out_valid, out_stall, out_data pol_pkg::out_word_t
//
// One word is taken at a time. After capture, a non-dump operation shifts the
// cell chain and loads the result register, while a dump clears the dump
// pointer, then streams one element per cycle, unless stalled, through the
// single read port on the cell chain; an empty dump behaves as a non-dump. A
// result waiting on out_stall holds the next stage only once the following
// result is ready; the input side reopens as soon as the result is loaded.
// Reset (rst_n low, synchronous) empties the list; no clearing pass is needed.
module positional_ordered_list #(
  parameter int LIST_DEPTH = pol_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pol_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pol_pkg::out_word_t out_data
);

  // command and status between sequencer and datapath
  pol_pkg::ctl_cmd_t cmd;
  pol_pkg::dp_stat_t stat;

  // sequencer: capture, execute, then stream elements for a dump
  pol_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // cell chain, count and the result register
  pol_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

### src/pol_checker.sv
// pol_checker: port-level assertions for positional_ordered_list.
// Depends on pol_pkg; attached to the top level by the bind below.
module pol_checker #(
  parameter int LIST_DEPTH = pol_pkg::DEPTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pol_pkg::out_word_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // one word in flight: the input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // an error status carries no element and closes the item
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != pol_pkg::ST_OK |-> out_data.last && out_data.element == '0)
    else $error("error result not a single zero word");

  // empty status only with an empty list
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == pol_pkg::ST_EMPTY |-> out_data.length == '0)
    else $error("empty status with non-zero length");

  // full status only at capacity
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == pol_pkg::ST_FULL
      |-> out_data.length == pol_pkg::LEN_W'(LIST_DEPTH))
    else $error("full status below capacity");

endmodule

bind positional_ordered_list pol_checker #(.LIST_DEPTH(LIST_DEPTH)) u_pol_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### sim/testbench.sv
// testbench: self-checking bench for positional_ordered_list.
// Depends on pol_pkg and the RTL under src; runs a directed table, then random words,
// all scored against an in-bench model of the list.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pol_pkg::*;

  localparam int LIST_CAP       = DEPTH_DEF;
  localparam int RANDOM_WORDS   = 320;
  localparam int WATCHDOG_LIMIT = 500;   // quiet cycles before giving up
  localparam int TAIL_CYCLES    = 40;    // longest dump plus slack

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  positional_ordered_list #(.LIST_DEPTH(LIST_CAP)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // List model: a shadow copy of the cells and the element count, updated as
  // each input word is accepted. Result words it predicts wait in
  // pending_results until the output side delivers them, oldest first.
  // ---------------------------------------------------------------------------
  logic signed [ELEM_W-1:0] shadow_cells [LIST_CAP];
  int unsigned              shadow_len = 0;
  out_word_t                pending_results [$];
  int unsigned              mismatch_count = 0;

  // Open a gap at slot and drop the value in; refuse when full or past the tail.
  function automatic logic [STAT_W-1:0] shadow_insert(logic signed [ELEM_W-1:0] v,
                                                      int unsigned slot);
    if (shadow_len >= LIST_CAP) return ST_FULL;
    if (slot > shadow_len) return ST_RANGE;
    for (int unsigned i = shadow_len; i > slot; i--) shadow_cells[i] = shadow_cells[i - 1];
    shadow_cells[slot] = v;
    shadow_len++;
    return ST_OK;
  endfunction

  // Close the gap at slot; emptiness is reported ahead of a bad position.
  function automatic logic [STAT_W-1:0] shadow_remove(int unsigned slot);
    if (shadow_len == 0) return ST_EMPTY;
    if (slot >= shadow_len) return ST_RANGE;
    for (int unsigned i = slot; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i + 1];
    shadow_len--;
    return ST_OK;
  endfunction

  // Apply one accepted word to the shadow list and queue the result words it causes.
  function automatic void predict_list_results(in_word_t w);
    logic [STAT_W-1:0] st;
    int unsigned       slot;
    st   = ST_OK;
    slot = (w.position == 0) ? 0 : int'(w.position) - 1;
    case (func_t'(w.func))
      F_INS_HEAD: st = shadow_insert(w.value, 0);
      F_INS_TAIL: st = shadow_insert(w.value, shadow_len);
      F_INS_AT: begin
        // position zero is out of range, but a full list is reported first
        if (w.position == 0) st = (shadow_len >= LIST_CAP) ? ST_FULL : ST_RANGE;
        else                 st = shadow_insert(w.value, slot);
      end
      F_DEL_HEAD: st = shadow_remove(0);
      F_DEL_AT: begin
        // position zero is out of range, but an empty list is reported first
        if (w.position == 0) st = (shadow_len == 0) ? ST_EMPTY : ST_RANGE;
        else                 st = shadow_remove(slot);
      end
      F_DEL_TAIL: st = shadow_remove((shadow_len == 0) ? 0 : shadow_len - 1);
      F_DUMP: begin
        // A non-empty dump streams head to tail, last on the tail element;
        // an empty one falls through to the single plain result below.
        if (shadow_len != 0) begin
          for (int unsigned i = 0; i < shadow_len; i++)
            pending_results.push_back('{status: ST_OK, element: shadow_cells[i],
                                        length: LEN_W'(shadow_len),
                                        last: (i + 1 == shadow_len)});
          return;
        end
      end
      default: st = ST_OK;
    endcase
    pending_results.push_back('{status: st, element: '0, length: LEN_W'(shadow_len),
                                last: 1'b1});
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Each word waits a gap drawn at random before it is offered, except
  // during burst stretches, where words follow back to back. Valid is lowered
  // only when a gap is taken, so it never gets two assignments in one step.
  // ---------------------------------------------------------------------------
  bit in_burst = 1'b0;

  task automatic send_word(in_word_t w);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    // hold the word until an edge sees valid with no stall
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_list_results(w);
  endtask

  // ---------------------------------------------------------------------------
  // Output side. Before each result word, stall for a spell drawn at random (none during
  // burst stretches), then release and wait for the word to be taken.
  // ---------------------------------------------------------------------------
  initial begin : result_pacing
    int unsigned hold;
    bit          out_burst;
    out_burst = 1'b0;
    forever begin
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 15);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Score every result word taken at an edge against the oldest prediction.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d element %0d length %0d last %0b",
               out_data.status, out_data.element, out_data.length, out_data.last);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.element !== want.element) begin
          $error("element: expected %0d, got %0d", want.element, out_data.element);
          mismatch_count++;
        end
        if (out_data.length !== want.length) begin
          $error("length: expected %0d, got %0d", want.length, out_data.length);
          mismatch_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a long run of edges with no word moving on either side is a hang.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. Rows marked typed carry the single result that can be read
  // straight off the list rules; the rest are scored by the model alone.
  // A row with reps above one repeats with a fresh random value each time.
  // ---------------------------------------------------------------------------
  typedef struct {
    func_t                    op;
    logic signed [ELEM_W-1:0] value;
    logic [POS_W-1:0]         position;
    int unsigned              reps;
    bit                       typed;
    logic [STAT_W-1:0]        status;
    int unsigned              length;
  } plan_row_t;

  localparam int PLAN_ROWS = 20;
  plan_row_t directed_plan [PLAN_ROWS] = '{
    // empty list: plain dump, then every delete reports empty
    '{F_DUMP,     32'sd0,          8'd1,   1,  1'b1, ST_OK,    0},
    '{F_DEL_HEAD, 32'sd0,          8'd1,   1,  1'b1, ST_EMPTY, 0},
    '{F_DEL_AT,   32'sd0,          8'd1,   1,  1'b1, ST_EMPTY, 0},
    '{F_DEL_TAIL, 32'sd0,          8'd1,   1,  1'b1, ST_EMPTY, 0},
    // insert past count+1 on an empty list
    '{F_INS_AT,   32'sd5,          8'd2,   1,  1'b1, ST_RANGE, 0},
    // value extremes, and a positional insert right at count+1
    '{F_INS_HEAD, 32'h7fff_ffff,   8'd1,   1,  1'b1, ST_OK,    1},
    '{F_INS_TAIL, 32'h8000_0000,   8'd1,   1,  1'b1, ST_OK,    2},
    '{F_INS_AT,   -32'sd1,         8'd3,   1,  1'b1, ST_OK,    3},
    '{F_INS_AT,   32'sd9,          8'd255, 1,  1'b1, ST_RANGE, 3},
    '{F_DEL_AT,   32'sd0,          8'd4,   1,  1'b1, ST_RANGE, 3},
    // fill to capacity through the middle of the list
    '{F_INS_AT,   32'sd0,          8'd2,   13, 1'b0, ST_OK,    0},
    // full list: every insert refused, fullness ahead of the position
    '{F_INS_HEAD, 32'sd1,          8'd1,   1,  1'b1, ST_FULL,  LIST_CAP},
    '{F_INS_TAIL, 32'sd1,          8'd1,   1,  1'b1, ST_FULL,  LIST_CAP},
    '{F_INS_AT,   32'sd1,          8'd255, 1,  1'b1, ST_FULL,  LIST_CAP},
    '{F_DUMP,     32'sd0,          8'd1,   1,  1'b0, ST_OK,    0},
    // delete at the tail position, beyond it, then both ends
    '{F_DEL_AT,   32'sd0,          8'd16,  1,  1'b1, ST_OK,    LIST_CAP - 1},
    '{F_DEL_AT,   32'sd0,          8'd255, 1,  1'b1, ST_RANGE, LIST_CAP - 1},
    '{F_DEL_HEAD, 32'sd0,          8'd1,   1,  1'b1, ST_OK,    LIST_CAP - 2},
    '{F_DEL_TAIL, 32'sd0,          8'd1,   1,  1'b1, ST_OK,    LIST_CAP - 3},
    '{F_DUMP,     32'sd0,          8'd1,   1,  1'b0, ST_OK,    0}
  };

  initial begin : stimulus
    in_word_t    w;
    bit          growing;
    bit          is_insert;
    int unsigned pick;
    int unsigned pos_limit;
    func_t       insert_ops [3];
    func_t       delete_ops [3];
    insert_ops = '{F_INS_HEAD, F_INS_TAIL, F_INS_AT};
    delete_ops = '{F_DEL_HEAD, F_DEL_AT, F_DEL_TAIL};
    growing    = 1'b1;

    // hold reset, then release it in step with the clock
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[r]) begin
      for (int unsigned k = 0; k < directed_plan[r].reps; k++) begin
        w.func     = directed_plan[r].op;
        w.value    = (directed_plan[r].reps > 1) ? $urandom : directed_plan[r].value;
        w.position = directed_plan[r].position;
        send_word(w);
        // a typed row replaces the model's word with the one written in the table
        if (directed_plan[r].typed)
          pending_results[pending_results.size() - 1] =
            '{status: directed_plan[r].status, element: '0,
              length: LEN_W'(directed_plan[r].length), last: 1'b1};
      end
    end

    // Random part: drift the list between empty and full so both limits are
    // hit repeatedly; most positions are legal, about one in twelve is past
    // the end, and one value in ten is an extreme.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (shadow_len == LIST_CAP) growing = 1'b0;
      else if (shadow_len == 0) growing = 1'b1;
      else if ($urandom_range(0, 39) == 0) growing = !growing;

      w.value = $urandom;
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       w.value = 32'h7fff_ffff;
          1:       w.value = 32'h8000_0000;
          2:       w.value = '0;
          default: w.value = '1;
        endcase
      end

      pick      = $urandom_range(0, 99);
      is_insert = ($urandom_range(0, 99) < (growing ? 75 : 25));
      if (pick < 10) w.func = F_DUMP;
      else if (is_insert) w.func = insert_ops[$urandom_range(0, 2)];
      else w.func = delete_ops[$urandom_range(0, 2)];

      pos_limit = is_insert ? shadow_len + 1 : ((shadow_len == 0) ? 1 : shadow_len);
      if ($urandom_range(0, 11) == 0) w.position = POS_W'($urandom_range(pos_limit + 1, 255));
      else w.position = POS_W'($urandom_range(1, pos_limit));

      send_word(w);
    end
    in_valid <= 1'b0;

    // drain: every predicted word must arrive, then watch a while for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
